FILE: hw/rtl/mer_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared widths, register indexes, colour codes and inter-module structs.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int RADIUS_BITS = 10;
    localparam int SQ_W        = 2 * RADIUS_BITS;      // radius squared
    localparam int CMP_W       = 3 * RADIUS_BITS;      // radius squared times coordinate
    localparam int MUL_W       = 2 * RADIUS_BITS + 2;  // shared multiplier operand
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DEC_W       = 48;                   // decision value, wraps mod 2^48
    localparam int PIX_W       = 12;
    localparam int COL_W       = 2;

    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;

    localparam int CFG_IDX_W   = 2;

    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = Q_PTR_W + 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd3;

    localparam logic [RADIUS_BITS-1:0] RADIUS_X_RESET = 10'd300;
    localparam logic [RADIUS_BITS-1:0] RADIUS_Y_RESET = 10'd150;
    localparam logic [RADIUS_BITS-1:0] CENTER_X_RESET = 10'd319;
    localparam logic [RADIUS_BITS-1:0] CENTER_Y_RESET = 10'd237;

    // Colour codes
    localparam logic [COL_W-1:0] COL_YELLOW = 2'd0;
    localparam logic [COL_W-1:0] COL_GREEN  = 2'd1;
    localparam logic [COL_W-1:0] COL_BLUE   = 2'd2;
    localparam logic [COL_W-1:0] COL_RED    = 2'd3;

    // Ellipse geometry seen by the walker
    typedef struct packed {
        logic [SQ_W-1:0]        rx2;
        logic [SQ_W-1:0]        ry2;
        logic [RADIUS_BITS-1:0] ry;
        logic [RADIUS_BITS-1:0] cx;
        logic [RADIUS_BITS-1:0] cy;
    } geom_t;

    // Head of the command queue
    typedef struct packed {
        logic valid;
        logic restart;
    } cmd_head_t;

endpackage

FILE: hw/rtl/mer_front.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer front end
// Accepts input items, classifies them as restart or step, and queues them.
// ----------------------------------------------------------------------------
module mer_front import mer_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [0] restart
    input  logic                 pop,
    output cmd_head_t            head
);

    logic               q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push;
    logic               do_pop;

    assign s_tready     = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign push         = s_tvalid & s_tready;
    assign do_pop       = pop & head.valid;
    assign head.valid   = (count_reg != '0);
    assign head.restart = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= s_tdata[0];
        end
    end

endmodule

FILE: hw/rtl/mer_back.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer back end
// Walks the ellipse one command at a time on a shared multiplier and emits
// the mirrored pixels and done items through a one-item output register.
// ----------------------------------------------------------------------------
module mer_back import mer_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  geom_t                geom,
    input  cmd_head_t            head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [11:0] pixel_x, [23:12] pixel_y, [25:24] colour
    output logic                 m_tuser,   // [0] done_res
    output logic                 m_tlast
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RESTART = 5'd1;
    localparam logic [4:0] ST_A_CMP0  = 5'd2;
    localparam logic [4:0] ST_A_CMP1  = 5'd3;
    localparam logic [4:0] ST_A_DIAG0 = 5'd4;
    localparam logic [4:0] ST_A_DIAG1 = 5'd5;
    localparam logic [4:0] ST_B_TX    = 5'd6;
    localparam logic [4:0] ST_B_TY    = 5'd7;
    localparam logic [4:0] ST_B_RX    = 5'd8;
    localparam logic [4:0] ST_B_RY    = 5'd9;
    localparam logic [4:0] ST_B_END   = 5'd10;
    localparam logic [4:0] ST_C_RUN   = 5'd11;
    localparam logic [4:0] ST_C_DIAG  = 5'd12;
    localparam logic [4:0] ST_EMIT    = 5'd13;
    localparam logic [4:0] ST_DONE    = 5'd14;

    logic [4:0]             state_reg, state_next;
    logic [RADIUS_BITS-1:0] walk_x_reg, walk_x_next;
    logic [RADIUS_BITS-1:0] walk_y_reg, walk_y_next;
    logic [DEC_W-1:0]       dec_reg, dec_next;
    logic                   region2_reg, region2_next;
    logic                   finished_reg, finished_next;
    logic [DEC_W-1:0]       acc_reg, acc_next;
    logic [CMP_W-1:0]       p1_reg, p1_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [1:0]             idx_reg, idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]       out_px_reg, out_px_next;
    logic [PIX_W-1:0]       out_py_reg, out_py_next;
    logic [COL_W-1:0]       out_col_reg, out_col_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_done_reg, out_done_next;

    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;

    logic                   out_free;
    logic                   dec_neg;
    logic [DEC_W-1:0]       prod_ext;
    logic [DEC_W-1:0]       rx2_ext;
    logic [DEC_W-1:0]       ry2_ext;
    logic [DEC_W-1:0]       a_sum;
    logic [DEC_W-1:0]       c_sum;
    logic [RADIUS_BITS:0]   x_inc;
    logic [RADIUS_BITS+1:0] x_dbl3;
    logic [RADIUS_BITS:0]   tx;
    logic [RADIUS_BITS-1:0] y_dec;
    logic [RADIUS_BITS-1:0] ty_abs;
    logic [PIX_W-1:0]       xp, xm, yp, ym;
    logic                   minus_x;
    logic                   minus_y;
    logic [COL_W-1:0]       pix_col;

    assign out_free = !out_valid_reg || m_tready;
    assign dec_neg  = dec_reg[DEC_W-1];
    assign prod_ext = DEC_W'(prod_reg);
    assign rx2_ext  = DEC_W'(geom.rx2);
    assign ry2_ext  = DEC_W'(geom.ry2);
    assign x_inc    = {1'b0, walk_x_reg} + 1'b1;
    assign x_dbl3   = {1'b0, walk_x_reg, 1'b1} + 2'd2;
    assign tx       = {walk_x_reg, 1'b1};
    assign y_dec    = walk_y_reg - 1'b1;
    // (y - 1)^2 with y = 0 wraps to (-1)^2
    assign ty_abs   = (walk_y_reg == '0) ? RADIUS_BITS'(1) : y_dec;

    // region 1 diagonal/horizontal partial, region 2 common partial
    assign a_sum    = dec_reg + (prod_ext << 2);
    assign c_sum    = dec_reg - (prod_ext << 3) + (rx2_ext << 3) + (rx2_ext << 2);

    assign xp = PIX_W'(geom.cx) + PIX_W'(walk_x_reg);
    assign xm = PIX_W'(geom.cx) - PIX_W'(walk_x_reg);
    assign yp = PIX_W'(geom.cy) + PIX_W'(walk_y_reg);
    assign ym = PIX_W'(geom.cy) - PIX_W'(walk_y_reg);

    // region 2 swaps the first two colours and the order of the lower pair
    assign minus_x = region2_reg ? (idx_reg[0] ^ idx_reg[1]) : idx_reg[0];
    assign minus_y = idx_reg[1];
    assign pix_col = (region2_reg && !idx_reg[1]) ? {1'b0, ~idx_reg[0]} : idx_reg;

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        state_next     = state_reg;
        walk_x_next    = walk_x_reg;
        walk_y_next    = walk_y_reg;
        dec_next       = dec_reg;
        region2_next   = region2_reg;
        finished_next  = finished_reg;
        acc_next       = acc_reg;
        p1_next        = p1_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        out_valid_next = out_valid_reg && !m_tready;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.restart)
                    begin
                        mul_a      = MUL_W'(geom.rx2);
                        mul_b      = MUL_W'(geom.ry);
                        state_next = ST_RESTART;
                    end
                    else if (finished_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (!region2_reg)
                    begin
                        mul_a      = MUL_W'(geom.ry2);
                        mul_b      = MUL_W'(walk_x_reg);
                        state_next = ST_A_CMP0;
                    end
                    else if (walk_y_reg == '0)
                    begin
                        finished_next = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        mul_a      = MUL_W'(geom.rx2);
                        mul_b      = MUL_W'(walk_y_reg);
                        state_next = ST_C_RUN;
                    end
                end
            end

            ST_RESTART:
            begin
                dec_next      = (ry2_ext << 2) - (prod_ext << 2) + rx2_ext;
                walk_x_next   = '0;
                walk_y_next   = geom.ry;
                region2_next  = 1'b0;
                finished_next = 1'b0;
                state_next    = ST_IDLE;
            end

            ST_A_CMP0:
            begin
                p1_next    = prod_reg[CMP_W-1:0];
                mul_a      = MUL_W'(geom.rx2);
                mul_b      = MUL_W'(walk_y_reg);
                state_next = ST_A_CMP1;
            end

            ST_A_CMP1:
            begin
                if (p1_reg < prod_reg[CMP_W-1:0])
                begin
                    mul_a      = MUL_W'(geom.ry2);
                    mul_b      = MUL_W'(x_dbl3);
                    state_next = ST_A_DIAG0;
                end
                else
                begin
                    // region 1 test failed: build the region 2 start value
                    mul_a      = MUL_W'(tx);
                    mul_b      = MUL_W'(tx);
                    state_next = ST_B_TX;
                end
            end

            ST_A_DIAG0:
            begin
                if (dec_neg)
                begin
                    dec_next    = a_sum;
                    walk_x_next = walk_x_reg + 1'b1;
                    idx_next    = '0;
                    state_next  = ST_EMIT;
                end
                else
                begin
                    acc_next   = a_sum;
                    mul_a      = MUL_W'(geom.rx2);
                    mul_b      = MUL_W'(y_dec);
                    state_next = ST_A_DIAG1;
                end
            end

            ST_A_DIAG1:
            begin
                dec_next    = acc_reg - (prod_ext << 3);
                walk_x_next = walk_x_reg + 1'b1;
                walk_y_next = y_dec;
                idx_next    = '0;
                state_next  = ST_EMIT;
            end

            ST_B_TX:
            begin
                mul_a      = MUL_W'(geom.ry2);
                mul_b      = prod_reg[MUL_W-1:0];
                state_next = ST_B_TY;
            end

            ST_B_TY:
            begin
                acc_next   = prod_ext;
                mul_a      = MUL_W'(ty_abs);
                mul_b      = MUL_W'(ty_abs);
                state_next = ST_B_RX;
            end

            ST_B_RX:
            begin
                mul_a      = MUL_W'(geom.rx2);
                mul_b      = MUL_W'(prod_reg[SQ_W-1:0]);
                state_next = ST_B_RY;
            end

            ST_B_RY:
            begin
                acc_next   = acc_reg + (prod_ext << 2);
                mul_a      = MUL_W'(geom.rx2);
                mul_b      = MUL_W'(geom.ry2);
                state_next = ST_B_END;
            end

            ST_B_END:
            begin
                dec_next     = acc_reg - (prod_ext << 2);
                region2_next = 1'b1;
                // continue as a region 2 step in the same item
                if (walk_y_reg == '0)
                begin
                    finished_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    mul_a      = MUL_W'(geom.rx2);
                    mul_b      = MUL_W'(walk_y_reg);
                    state_next = ST_C_RUN;
                end
            end

            ST_C_RUN:
            begin
                if (dec_neg)
                begin
                    acc_next   = c_sum;
                    mul_a      = MUL_W'(geom.ry2);
                    mul_b      = MUL_W'(x_inc);
                    state_next = ST_C_DIAG;
                end
                else
                begin
                    dec_next    = c_sum;
                    walk_y_next = y_dec;
                    idx_next    = '0;
                    state_next  = ST_EMIT;
                end
            end

            ST_C_DIAG:
            begin
                dec_next    = acc_reg + (prod_ext << 3);
                walk_x_next = walk_x_reg + 1'b1;
                walk_y_next = y_dec;
                idx_next    = '0;
                state_next  = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_px_next    = minus_x ? xm : xp;
                    out_py_next    = minus_y ? ym : yp;
                    out_col_next   = pix_col;
                    out_last_next  = (idx_reg == 2'd3);
                    out_done_next  = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_px_next    = '0;
                    out_py_next    = '0;
                    out_col_next   = COL_YELLOW;
                    out_last_next  = 1'b1;
                    out_done_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            walk_x_reg    <= '0;
            walk_y_reg    <= '0;
            dec_reg       <= '0;
            region2_reg   <= 1'b0;
            finished_reg  <= 1'b1;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_x_reg    <= walk_x_next;
            walk_y_reg    <= walk_y_next;
            dec_reg       <= dec_next;
            region2_reg   <= region2_next;
            finished_reg  <= finished_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        p1_reg       <= p1_next;
        prod_reg     <= prod_next;
        out_px_reg   <= out_px_next;
        out_py_reg   <= out_py_next;
        out_col_reg  <= out_col_next;
        out_last_reg <= out_last_next;
        out_done_reg <= out_done_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2 * PIX_W - COL_W){1'b0}}, out_col_reg, out_py_reg,
                       out_px_reg};
    assign m_tuser  = out_done_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: hw/rtl/midpoint_ellipse_rasterizer.sv
// Restart item: passes through ST_RESTART in the walker, no result; a finished walk gives one done item.
// Region 1 step: A_CMP0, A_CMP1, A_DIAG0 [, A_DIAG1], then 4 pixel items, one per cycle unless stalled.
// Region change: A_CMP0/1, B_TX..B_END, then as region 2; region 2 step: C_RUN [, C_DIAG], 4 items.
// Rate is set by the single shared 22x22 multiplier and the one-item output register.
// Reset: radii 300/150, center (319, 237), walk finished so a step gives a done item.
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Holds the geometry registers and joins the command front end to the walker.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,    // [0] restart
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // [11:0] pixel_x, [23:12] pixel_y, [25:24] colour
    output logic                   m_tuser,    // [0] done_res
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [RADIUS_BITS-1:0] cfg_data
);

    logic [RADIUS_BITS-1:0] rx_reg;
    logic [RADIUS_BITS-1:0] ry_reg;
    logic [RADIUS_BITS-1:0] cx_reg;
    logic [RADIUS_BITS-1:0] cy_reg;
    logic [SQ_W-1:0]        rx2_reg;
    logic [SQ_W-1:0]        ry2_reg;
    geom_t                  geom;
    cmd_head_t              head;
    logic                   pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg <= RADIUS_X_RESET;
            ry_reg <= RADIUS_Y_RESET;
            cx_reg <= CENTER_X_RESET;
            cy_reg <= CENTER_Y_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIUS_X: rx_reg <= cfg_data;
                REG_RADIUS_Y: ry_reg <= cfg_data;
                REG_CENTER_X: cx_reg <= cfg_data;
                REG_CENTER_Y: cy_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // register the squared radii, which follow the radius registers in the next cycle
    always_ff @(posedge clk)
    begin
        rx2_reg <= SQ_W'(rx_reg) * SQ_W'(rx_reg);
        ry2_reg <= SQ_W'(ry_reg) * SQ_W'(ry_reg);
    end

    assign geom.rx2 = rx2_reg;
    assign geom.ry2 = ry2_reg;
    assign geom.ry  = ry_reg;
    assign geom.cx  = cx_reg;
    assign geom.cy  = cy_reg;

    mer_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .pop      (pop),
        .head     (head)
    );

    mer_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("done item must be last and carry no pixel");

    a_last_red: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tlast == (m_tdata[2*PIX_W +: COL_W] == COL_RED)))
        else $error("pixel item last flag does not match final colour");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("walker popped an empty command queue");

endmodule
